// File: sv/steer_zone_timeout_commander_defines.svh
// ----------------------------------------------------------------------------
// Steer zone timeout commander assertion macros
// Shared property macros for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef STEER_ZONE_TIMEOUT_COMMANDER_DEFINES_SVH
`define STEER_ZONE_TIMEOUT_COMMANDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SZT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SZT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/szt_pkg.sv
// ----------------------------------------------------------------------------
// Steer zone timeout commander package
// Payload types, configuration types and fixed thresholds.
// ----------------------------------------------------------------------------
package szt_pkg;

   // Request and result payloads
   typedef struct packed {
      logic [15:0] position;
      logic        fresh;
   } req_type;

   typedef struct packed {
      logic        motor_enable;
      logic [1:0]  direction;
      logic [7:0]  duty;
      logic [20:0] on_time;
      logic [31:0] command_word;
   } rsp_type;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [15:0] timeout_ticks;
      logic [15:0] stop_ticks;
      logic [7:0]  drive_duty;
      logic [20:0] pulse_ticks;
   } cfg_type;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_TICKS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_TICKS    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_DUTY    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_TICKS   = 8'd3;

   // Register reset values
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd300;
   localparam logic [15:0] STOP_TICKS_RST    = 16'd300;
   localparam logic [7:0]  DRIVE_DUTY_RST    = 8'd80;
   localparam logic [20:0] PULSE_TICKS_RST   = 21'd78125;

   // Direction codes
   localparam logic [1:0] DIR_CENTER = 2'd0;
   localparam logic [1:0] DIR_RIGHT  = 2'd1;
   localparam logic [1:0] DIR_LEFT   = 2'd2;

   // Position thresholds, Q0.16
   localparam logic [15:0] ZONE_C_LO    = 16'd32441;
   localparam logic [15:0] ZONE_C_HI    = 16'd33095;
   localparam logic [15:0] ZONE_L4_LT   = 16'd8192;
   localparam logic [15:0] ZONE_L3_LT   = 16'd16384;
   localparam logic [15:0] ZONE_L2_LT   = 16'd24576;
   localparam logic [15:0] ZONE_R1_LE   = 16'd40960;
   localparam logic [15:0] ZONE_R2_LE   = 16'd49152;
   localparam logic [15:0] ZONE_R3_LE   = 16'd57344;
   localparam logic [15:0] SEARCH_LEFT  = 16'd6553;
   localparam logic [15:0] SEARCH_RIGHT = 16'd58983;

   localparam logic [15:0] AGE_MAX = 16'hFFFF;

endpackage

// File: sv/szt_csr.sv
// ----------------------------------------------------------------------------
// Steer zone timeout commander register file
// Holds the four configuration registers written over the csr port.
// ----------------------------------------------------------------------------
module szt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic [szt_pkg::CSR_INDEX_W-1:0]    wr_index,
   input  logic [szt_pkg::CSR_DATA_W-1:0]     wr_data,
   output szt_pkg::cfg_type                   cfg
);

   szt_pkg::cfg_type cfg_ff;
   szt_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            szt_pkg::CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = wr_data[15:0];
            szt_pkg::CSR_STOP_TICKS:    cfg_in.stop_ticks    = wr_data[15:0];
            szt_pkg::CSR_DRIVE_DUTY:    cfg_in.drive_duty    = wr_data[7:0];
            szt_pkg::CSR_PULSE_TICKS:   cfg_in.pulse_ticks   = wr_data[20:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ticks <= szt_pkg::TIMEOUT_TICKS_RST;
         cfg_ff.stop_ticks    <= szt_pkg::STOP_TICKS_RST;
         cfg_ff.drive_duty    <= szt_pkg::DRIVE_DUTY_RST;
         cfg_ff.pulse_ticks   <= szt_pkg::PULSE_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/szt_core.sv
// ----------------------------------------------------------------------------
// Steer zone timeout commander tick logic
// Tracking state and the per-tick command decision.
// ----------------------------------------------------------------------------
module szt_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  szt_pkg::req_type  item,
   input  szt_pkg::cfg_type  cfg,
   output logic              emit,
   output szt_pkg::rsp_type  rsp
);

   logic              started_ff, started_in;
   logic [15:0]       age_ff, age_in;
   logic [15:0]       stop_ff, stop_in;
   logic signed [3:0] zone_ff, zone_in;
   logic signed [3:0] zone_w;
   logic              enable_w;
   logic [1:0]        dir_w;
   logic [7:0]        duty_w;

   // Sort the position into nine zones
   always_comb begin
      if (item.position >= szt_pkg::ZONE_C_LO && item.position <= szt_pkg::ZONE_C_HI) begin
         zone_w = 4'sd0;
      end else if (item.position < szt_pkg::ZONE_L4_LT) begin
         zone_w = -4'sd4;
      end else if (item.position < szt_pkg::ZONE_L3_LT) begin
         zone_w = -4'sd3;
      end else if (item.position < szt_pkg::ZONE_L2_LT) begin
         zone_w = -4'sd2;
      end else if (item.position < szt_pkg::ZONE_C_LO) begin
         zone_w = -4'sd1;
      end else if (item.position <= szt_pkg::ZONE_R1_LE) begin
         zone_w = 4'sd1;
      end else if (item.position <= szt_pkg::ZONE_R2_LE) begin
         zone_w = 4'sd2;
      end else if (item.position <= szt_pkg::ZONE_R3_LE) begin
         zone_w = 4'sd3;
      end else begin
         zone_w = 4'sd4;
      end
   end

   always_comb begin
      started_in = started_ff;
      age_in     = age_ff;
      stop_in    = stop_ff;
      zone_in    = zone_ff;
      emit       = 1'b0;
      enable_w   = 1'b0;
      dir_w      = szt_pkg::DIR_CENTER;
      duty_w     = 8'd0;

      // Age the last update
      if (item.fresh) begin
         started_in = 1'b1;
         age_in     = 16'd0;
      end else if (started_ff && age_ff != szt_pkg::AGE_MAX) begin
         age_in = age_ff + 16'd1;
      end

      if (started_in) begin
         if (age_in < cfg.timeout_ticks) begin
            stop_in = 16'd0;
            if (zone_w != zone_ff) begin
               zone_in  = zone_w;
               emit     = 1'b1;
               enable_w = 1'b1;
               duty_w   = cfg.drive_duty;
               if (zone_w[3]) begin
                  dir_w = szt_pkg::DIR_LEFT;
               end else if (zone_w == 4'sd0) begin
                  dir_w = szt_pkg::DIR_CENTER;
               end else begin
                  dir_w = szt_pkg::DIR_RIGHT;
               end
            end
         end else if (stop_ff < cfg.stop_ticks) begin
            // stop_ff stays below stop_ticks here, so the increment cannot wrap
            stop_in = stop_ff + 16'd1;
            emit    = 1'b1;
         end else if (item.position <= szt_pkg::SEARCH_LEFT) begin
            emit     = 1'b1;
            enable_w = 1'b1;
            duty_w   = cfg.drive_duty;
            dir_w    = szt_pkg::DIR_LEFT;
         end else if (item.position >= szt_pkg::SEARCH_RIGHT) begin
            emit     = 1'b1;
            enable_w = 1'b1;
            duty_w   = cfg.drive_duty;
            dir_w    = szt_pkg::DIR_RIGHT;
         end
      end
   end

   always_comb begin
      rsp.motor_enable = enable_w;
      rsp.direction    = dir_w;
      rsp.duty         = duty_w;
      rsp.on_time      = cfg.pulse_ticks;
      rsp.command_word = {enable_w, dir_w, duty_w, cfg.pulse_ticks};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         age_ff     <= 16'd0;
         stop_ff    <= 16'd0;
         zone_ff    <= 4'sd0;
      end else if (advance) begin
         started_ff <= started_in;
         age_ff     <= age_in;
         stop_ff    <= stop_in;
         zone_ff    <= zone_in;
      end
   end

endmodule

// File: sv/steer_zone_timeout_commander.sv
// An accepted request is held in item_ff; its command is then registered into rsp_data_ff and rsp_valid.
// Throughput: one request per cycle unless a command is stalled; the decision is a single pass of compares.
// A request whose tick produces no command still takes its one slot.
// Synchronous active-high reset clears the tracking state and both stage
// valids and reloads the registers with their defaults (300, 300, 80, 78125).
// ----------------------------------------------------------------------------
// Steer zone timeout commander
// Turns position ticks into zone, stop and search steering commands.
// ----------------------------------------------------------------------------
module steer_zone_timeout_commander (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  szt_pkg::req_type                   req_data,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output szt_pkg::rsp_type                   rsp_data,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [szt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [szt_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   szt_pkg::cfg_type  cfg;
   szt_pkg::req_type  item_ff;
   logic              item_valid_ff;
   logic              out_free;
   logic              advance;
   logic              core_emit;
   szt_pkg::rsp_type  core_rsp;
   logic              rsp_valid_ff, rsp_valid_in;
   szt_pkg::rsp_type  rsp_data_ff;

   // Registers accept a write on every cycle
   assign csr_ready = 1'b1;

   szt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // The result register can load when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // Retire the held request into the tracking state
   assign advance  = item_valid_ff && out_free;
   // Hold the request register only while its tick cannot retire
   assign req_stall = item_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_data;
      end
   end

   szt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .emit    (core_emit),
      .rsp     (core_rsp)
   );

   // Load a command when a tick retires with one; drop the valid once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = advance && core_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && core_emit) begin
         rsp_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/szt_checker.sv
// ----------------------------------------------------------------------------
// Steer zone timeout commander port checker
// Watches the result channel for malformed or unstable commands.
// ----------------------------------------------------------------------------
`include "steer_zone_timeout_commander_defines.svh"

module szt_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  szt_pkg::rsp_type  rsp_data
);

   `SZT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled command changed")

   `SZT_ASSERT_NOW(a_word_packing, clock, reset, rsp_valid, rsp_data.command_word == {rsp_data.motor_enable, rsp_data.direction, rsp_data.duty, rsp_data.on_time}, "command word does not match its fields")

   `SZT_ASSERT_NOW(a_stop_form, clock, reset, rsp_valid && !rsp_data.motor_enable, rsp_data.direction == szt_pkg::DIR_CENTER && rsp_data.duty == 8'd0, "stop command carries drive")

   `SZT_ASSERT_NOW(a_dir_code, clock, reset, rsp_valid, rsp_data.direction == szt_pkg::DIR_CENTER || rsp_data.direction == szt_pkg::DIR_RIGHT || rsp_data.direction == szt_pkg::DIR_LEFT, "unused direction code")

endmodule

bind steer_zone_timeout_commander szt_checker u_szt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
